### design/ptce_pkg.sv
// Shared types, constants, CHS packing and entry-present helpers for the partition table encoder.
package ptce_pkg;

  localparam int unsigned NUM_ENTRIES = 4;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_EXISTS  = 2'd1;
  localparam logic [1:0] RC_INVALID = 2'd2;

  localparam logic [7:0] STATUS_EMPTY    = 8'h01;
  localparam logic [7:0] STATUS_ACTIVE   = 8'h80;
  localparam logic [7:0] STATUS_INACTIVE = 8'h00;

  localparam logic [5:0]  TRACK_SECTORS = 6'd63;
  localparam logic [31:0] CHS_LIMIT     = 32'd16370046;
  localparam logic [23:0] CHS_SATURATED = 24'hFEFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  entry_number;
    logic [7:0]  type_id;
    logic [31:0] lba_start;
    logic [31:0] lba_count;
  } ptce_in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic        present;
    logic [7:0]  entry_status;
    logic [7:0]  entry_type;
    logic [23:0] first_chs;
    logic [23:0] last_chs;
    logic [31:0] entry_lba_start;
    logic [31:0] entry_lba_count;
  } ptce_out_t;

  // quo = low 14 bits of lba / 63, rem = lba % 63; 16 heads, so head and cylinder come from quo
  function automatic logic [23:0] chs_pack(input logic [13:0] quo, input logic [5:0] rem);
    logic [5:0] sec;
    sec = rem + 6'd1;
    return {4'd0, quo[3:0], quo[13:12], sec, quo[11:4]};
  endfunction

  function automatic logic entry_present(input logic [7:0] status, input logic [7:0] ptype);
    return ((status == STATUS_INACTIVE) || (status == STATUS_ACTIVE)) && (ptype != 8'd0);
  endfunction

endpackage

### design/partition_table_chs_encoder.sv
// Partition table encoder. Query, delete, clear, refused add or bad entry number: the
// result is registered in ST_RESP after the input transaction is accepted and held in ST_OUT.
// An accepted add runs the start, then the end address (unless the end is saturated), through
// one shared shift-and-add divide-by-63 unit in ST_DIV before it goes on to ST_RESP.
// One transaction in flight; in_ready returns the cycle after the result is taken.
// Synchronous active-low reset empties all entries (status 0x01, rest zero).
module partition_table_chs_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptce_pkg::ptce_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptce_pkg::ptce_out_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESP,
    ST_OUT
  } state_t;

  state_t state_r;

  logic [7:0]  status_tab_r [ptce_pkg::NUM_ENTRIES];
  logic [7:0]  type_tab_r   [ptce_pkg::NUM_ENTRIES];
  logic [23:0] first_tab_r  [ptce_pkg::NUM_ENTRIES];
  logic [23:0] last_tab_r   [ptce_pkg::NUM_ENTRIES];
  logic [31:0] start_tab_r  [ptce_pkg::NUM_ENTRIES];
  logic [31:0] count_tab_r  [ptce_pkg::NUM_ENTRIES];

  logic [1:0]  idx_r;
  logic        num_ok_r;
  logic [1:0]  rc_r;
  logic [7:0]  type_r;
  logic [31:0] start_r;
  logic [31:0] count_r;
  logic [23:0] end_r;
  logic        sat_r;
  logic [23:0] first_r;
  logic        pass_r;

  logic [31:0] dvd_r;
  logic [13:0] quo_r;

  logic              out_valid_r;
  ptce_pkg::ptce_out_t out_r;

  // accept-side decode
  logic        in_fire;
  logic        in_num_ok;
  logic [1:0]  in_idx;
  logic [31:0] in_end;
  logic        in_sat;

  assign in_fire   = in_valid && in_ready;
  assign in_num_ok = (in_data.entry_number >= 3'd1) && (in_data.entry_number <= 3'd4);
  assign in_idx    = 2'(in_data.entry_number - 3'd1);
  assign in_end    = in_data.lba_start + in_data.lba_count;
  assign in_sat    = (in_end <= in_data.lba_start) || (in_end >= ptce_pkg::CHS_LIMIT);

  // one fold of the divide-by-63 unit: x = 64*t + l, so quotient += t and x becomes t + l
  logic        fold_go;
  logic [31:0] fold_dvd;
  logic [13:0] fold_quo;
  logic        fin_max;
  logic [13:0] fin_quo;
  logic [5:0]  fin_rem;

  assign fold_go  = (dvd_r[31:6] != 26'd0);
  assign fold_dvd = {6'd0, dvd_r[31:6]} + {26'd0, dvd_r[5:0]};
  assign fold_quo = quo_r + dvd_r[19:6];
  assign fin_max  = (dvd_r[5:0] == ptce_pkg::TRACK_SECTORS);
  assign fin_quo  = quo_r + {13'd0, fin_max};
  assign fin_rem  = fin_max ? 6'd0 : dvd_r[5:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ptce_pkg::NUM_ENTRIES; i++) begin
        status_tab_r[i] <= ptce_pkg::STATUS_EMPTY;
        type_tab_r[i]   <= 8'd0;
        first_tab_r[i]  <= 24'd0;
        last_tab_r[i]   <= 24'd0;
        start_tab_r[i]  <= 32'd0;
        count_tab_r[i]  <= 32'd0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            idx_r    <= in_idx;
            num_ok_r <= in_num_ok;
            type_r   <= in_data.type_id;
            start_r  <= in_data.lba_start;
            count_r  <= in_data.lba_count;
            end_r    <= in_end[23:0];
            sat_r    <= in_sat;
            if (in_data.opcode == ptce_pkg::OP_CLEAR) begin
              rc_r    <= ptce_pkg::RC_OK;
              state_r <= ST_RESP;
              for (int i = 0; i < ptce_pkg::NUM_ENTRIES; i++) begin
                status_tab_r[i] <= ptce_pkg::STATUS_EMPTY;
                type_tab_r[i]   <= 8'd0;
                first_tab_r[i]  <= 24'd0;
                last_tab_r[i]   <= 24'd0;
                start_tab_r[i]  <= 32'd0;
                count_tab_r[i]  <= 32'd0;
              end
            end else if (!in_num_ok) begin
              rc_r    <= ptce_pkg::RC_INVALID;
              state_r <= ST_RESP;
            end else if (in_data.opcode == ptce_pkg::OP_ADD) begin
              if (ptce_pkg::entry_present(status_tab_r[in_idx], type_tab_r[in_idx])) begin
                rc_r    <= ptce_pkg::RC_EXISTS;
                state_r <= ST_RESP;
              end else begin
                // start the divider on the first address
                rc_r    <= ptce_pkg::RC_OK;
                dvd_r   <= in_data.lba_start;
                quo_r   <= 14'd0;
                pass_r  <= 1'b0;
                state_r <= ST_DIV;
              end
            end else begin
              rc_r    <= ptce_pkg::RC_OK;
              state_r <= ST_RESP;
              if (in_data.opcode == ptce_pkg::OP_DEL) begin
                status_tab_r[in_idx] <= ptce_pkg::STATUS_EMPTY;
                type_tab_r[in_idx]   <= 8'd0;
                first_tab_r[in_idx]  <= 24'd0;
                last_tab_r[in_idx]   <= 24'd0;
                start_tab_r[in_idx]  <= 32'd0;
                count_tab_r[in_idx]  <= 32'd0;
              end
            end
          end
        end

        ST_DIV: begin
          if (fold_go) begin
            dvd_r <= fold_dvd;
            quo_r <= fold_quo;
          end else if (!pass_r && !sat_r) begin
            // end address fits in 24 bits: run it through the same unit
            first_r <= ptce_pkg::chs_pack(fin_quo, fin_rem);
            dvd_r   <= {8'd0, end_r};
            quo_r   <= 14'd0;
            pass_r  <= 1'b1;
          end else begin
            status_tab_r[idx_r] <= ptce_pkg::STATUS_INACTIVE;
            type_tab_r[idx_r]   <= type_r;
            start_tab_r[idx_r]  <= start_r;
            count_tab_r[idx_r]  <= count_r;
            if (pass_r) begin
              first_tab_r[idx_r] <= first_r;
              last_tab_r[idx_r]  <= ptce_pkg::chs_pack(fin_quo, fin_rem);
            end else begin
              first_tab_r[idx_r] <= ptce_pkg::chs_pack(fin_quo, fin_rem);
              last_tab_r[idx_r]  <= ptce_pkg::CHS_SATURATED;
            end
            state_r <= ST_RESP;
          end
        end

        ST_RESP: begin
          out_r.result_code <= rc_r;
          if (num_ok_r) begin
            out_r.present         <= ptce_pkg::entry_present(status_tab_r[idx_r],
                                                             type_tab_r[idx_r]);
            out_r.entry_status    <= status_tab_r[idx_r];
            out_r.entry_type      <= type_tab_r[idx_r];
            out_r.first_chs       <= first_tab_r[idx_r];
            out_r.last_chs        <= last_tab_r[idx_r];
            out_r.entry_lba_start <= start_tab_r[idx_r];
            out_r.entry_lba_count <= count_tab_r[idx_r];
          end else begin
            out_r.present         <= 1'b0;
            out_r.entry_status    <= 8'd0;
            out_r.entry_type      <= 8'd0;
            out_r.first_chs       <= 24'd0;
            out_r.last_chs        <= 24'd0;
            out_r.entry_lba_start <= 32'd0;
            out_r.entry_lba_count <= 32'd0;
          end
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end

        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a transaction was accepted");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.result_code == ptce_pkg::RC_INVALID)) |->
      (!out_data.present && (out_data.entry_status == 8'd0)))
    else $error("invalid entry number returned nonzero entry data");

  a_present_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.present) |-> (out_data.entry_type != 8'd0))
    else $error("entry reported present with zero type");

endmodule
